// ===== hdl/pfc_pkg.sv =====
// Shared types, command codes and letter constants for the Playfair block.
// Holds the transaction structs, the sequencer state enum and cell indexing.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_KEY   = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  localparam logic [4:0] LET_I       = 5'd8;
  localparam logic [4:0] LET_J       = 5'd9;
  localparam logic [4:0] LET_X       = 5'd23;
  localparam logic [4:0] NUM_LETTERS = 5'd26;
  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [4:0] SQ_CELLS    = 5'd25;
  localparam logic [4:0] SQ_SIDE     = 5'd5;
  localparam logic [2:0] SQ_LAST     = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] letter;
  } in_t;

  typedef struct packed {
    logic [4:0] cipher_letter;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_DECIDE,
    S_LOC,
    S_CALC,
    S_EMIT1,
    S_EMIT2
  } state_t;

  function automatic logic [4:0] cell_idx(input logic [2:0] row, input logic [2:0] col);
    cell_idx = ({2'b00, row} * SQ_SIDE) + {2'b00, col};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/playfair_digraph_cipher_top.sv =====
// Playfair encryption block: key square, letter-used flags and the sequencer.
// Depends on pfc_pkg for transaction types, command codes and constants.
//
// Usage: an input transaction carries cmd and letter (0 clear, 1 key letter,
// 2 plaintext letter, 3 end of message); j is taken as i. Each encrypted pair
// leaves as two output transactions, the second with last set.
// Clear and key letters are handled in the accepting cycle. A plaintext letter that
// only becomes pending passes through the decode state and returns to idle. The first
// plaintext letter after key entry first walks all 26 letters through the used
// flags to complete the square. A pair then passes the decode state, searches the
// square cell by cell with one shared comparator, up to all 25 cells per letter,
// and reads the cipher cells in the calc state: the first output transaction is
// registered there, the second is offered in the cycle after the first is taken.
// in_stall is high from the first cycle of that work until the second output
// transaction is taken: one item at a time.
// A stalled result holds its value and keeps the block busy.
// Reset empties the square and drops any pending letter; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module playfair_digraph_cipher_top
  import pfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  state_t      state_r, state_nxt;
  logic [4:0]  sq_r [SQ_CELLS];
  logic [25:0] used_r, used_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        ready_r, ready_nxt;
  logic        pv_r, pv_nxt;
  logic [4:0]  pl_r, pl_nxt;
  logic [1:0]  op_cmd_r, op_cmd_nxt;
  logic [4:0]  op_let_r, op_let_nxt;
  logic [4:0]  a_r, a_nxt;
  logic [4:0]  b_r, b_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [2:0]  col_r, col_nxt;
  logic        phase_r, phase_nxt;
  logic [2:0]  ra_r, ra_nxt, ca_r, ca_nxt, rb_r, rb_nxt, cb_r, cb_nxt;
  logic [4:0]  o2_r, o2_nxt;
  logic [4:0]  out_let_r, out_let_nxt;
  logic        out_last_r, out_last_nxt;

  logic        sq_we;
  logic [4:0]  sq_waddr, sq_wdata;
  logic [4:0]  rd_addr, rd_data;
  logic        accept;
  logic [4:0]  cm;
  logic [4:0]  target;
  logic [2:0]  ca_inc, cb_inc, ra_inc, rb_inc;
  logic [4:0]  o1, o2;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == S_EMIT1) || (state_r == S_EMIT2);
  assign out_data  = '{cipher_letter: out_let_r, last: out_last_r};
  assign cm        = (in_data.letter == LET_J) ? LET_I : in_data.letter;
  assign rd_data   = sq_r[rd_addr];
  assign target    = phase_r ? b_r : a_r;

  assign ca_inc = (ca_r == SQ_LAST) ? 3'd0 : ca_r + 3'd1;
  assign cb_inc = (cb_r == SQ_LAST) ? 3'd0 : cb_r + 3'd1;
  assign ra_inc = (ra_r == SQ_LAST) ? 3'd0 : ra_r + 3'd1;
  assign rb_inc = (rb_r == SQ_LAST) ? 3'd0 : rb_r + 3'd1;

  always_comb begin
    if (ra_r == rb_r) begin
      o1 = cell_idx(ra_r, ca_inc);
      o2 = cell_idx(rb_r, cb_inc);
    end else if (ca_r == cb_r) begin
      o1 = cell_idx(ra_inc, ca_r);
      o2 = cell_idx(rb_inc, cb_r);
    end else begin
      o1 = cell_idx(ra_r, cb_r);
      o2 = cell_idx(rb_r, ca_r);
    end
  end

  always_comb begin
    case (state_r)
      S_CALC:  rd_addr = o1;
      S_EMIT1: rd_addr = o2_r;
      default: rd_addr = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      fill_r  <= '0;
      ready_r <= 1'b0;
      pv_r    <= 1'b0;
      pl_r    <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      fill_r  <= fill_nxt;
      ready_r <= ready_nxt;
      pv_r    <= pv_nxt;
      pl_r    <= pl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_we) begin
      sq_r[sq_waddr] <= sq_wdata;
    end
    op_cmd_r   <= op_cmd_nxt;
    op_let_r   <= op_let_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    phase_r    <= phase_nxt;
    ra_r       <= ra_nxt;
    ca_r       <= ca_nxt;
    rb_r       <= rb_nxt;
    cb_r       <= cb_nxt;
    o2_r       <= o2_nxt;
    out_let_r  <= out_let_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    ready_nxt    = ready_r;
    pv_nxt       = pv_r;
    pl_nxt       = pl_r;
    op_cmd_nxt   = op_cmd_r;
    op_let_nxt   = op_let_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    idx_nxt      = idx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    phase_nxt    = phase_r;
    ra_nxt       = ra_r;
    ca_nxt       = ca_r;
    rb_nxt       = rb_r;
    cb_nxt       = cb_r;
    o2_nxt       = o2_r;
    out_let_nxt  = out_let_r;
    out_last_nxt = out_last_r;
    sq_we        = 1'b0;
    sq_waddr     = fill_r;
    sq_wdata     = cm;

    case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        row_nxt   = '0;
        col_nxt   = '0;
        phase_nxt = 1'b0;
        if (accept) begin
          op_cmd_nxt = in_data.cmd;
          op_let_nxt = cm;
          case (in_data.cmd)
            CMD_CLEAR: begin
              used_nxt  = '0;
              fill_nxt  = '0;
              ready_nxt = 1'b0;
              pv_nxt    = 1'b0;
              pl_nxt    = '0;
            end
            CMD_KEY: begin
              if (in_data.letter < NUM_LETTERS && !ready_r && !used_r[cm] &&
                  fill_r < SQ_CELLS) begin
                sq_we    = 1'b1;
                used_nxt = used_r | (26'd1 << cm);
                fill_nxt = fill_r + 5'd1;
              end
            end
            CMD_TEXT: begin
              if (in_data.letter < NUM_LETTERS) begin
                state_nxt = ready_r ? S_DECIDE : S_FILL;
              end
            end
            CMD_END: begin
              if (pv_r) begin
                state_nxt = ready_r ? S_DECIDE : S_FILL;
              end
            end
            default: ;
          endcase
        end
      end

      S_FILL: begin
        sq_wdata = idx_r;
        if (idx_r != LET_J && !used_r[idx_r] && fill_r < SQ_CELLS) begin
          sq_we    = 1'b1;
          used_nxt = used_r | (26'd1 << idx_r);
          fill_nxt = fill_r + 5'd1;
        end
        if (idx_r == LAST_LETTER) begin
          ready_nxt = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      S_DECIDE: begin
        a_nxt     = pl_r;
        b_nxt     = LET_X;
        state_nxt = S_LOC;
        if (op_cmd_r == CMD_END) begin
          pv_nxt = 1'b0;
        end else if (!pv_r) begin
          pl_nxt    = op_let_r;
          pv_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (op_let_r != pl_r) begin
          b_nxt  = op_let_r;
          pv_nxt = 1'b0;
        end
      end

      S_LOC: begin
        if (rd_data == target) begin
          idx_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
          if (!phase_r) begin
            ra_nxt    = row_r;
            ca_nxt    = col_r;
            phase_nxt = 1'b1;
          end else begin
            rb_nxt    = row_r;
            cb_nxt    = col_r;
            state_nxt = S_CALC;
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
          if (col_r == SQ_LAST) begin
            col_nxt = '0;
            row_nxt = row_r + 3'd1;
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end

      S_CALC: begin
        out_let_nxt  = rd_data;
        out_last_nxt = 1'b0;
        o2_nxt       = o2;
        state_nxt    = S_EMIT1;
      end

      S_EMIT1: begin
        if (!out_stall) begin
          out_let_nxt  = rd_data;
          out_last_nxt = 1'b1;
          state_nxt    = S_EMIT2;
        end
      end

      S_EMIT2: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pfc_checker.sv =====
// Port-level checker for playfair_digraph_cipher_top, bound to the top level.
// Depends on pfc_pkg for the transaction types and letter constants.
`timescale 1ns / 1ps
`default_nettype none

module pfc_checker
  import pfc_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid && out_data.last)
    else $error("second letter of a pair did not follow");

  a_end_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("extra output after a pair");

  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cipher_letter <= LAST_LETTER && out_data.cipher_letter != LET_J)
    else $error("cipher letter outside the square");

endmodule

bind playfair_digraph_cipher_top pfc_checker u_pfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
